// ===== hdl/xcpd_pkg.sv =====
package xcpd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] SYNC1_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] SYNC2_RST = 8'h55;
  localparam logic [WORD_W-1:0] MAX_PL_RST = 16'd256;

  localparam logic [KIND_W-1:0] KIND_DATA   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GOOD   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BADSUM = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BADLEN = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_SYNC1  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PL = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_CMD     = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  typedef struct packed {
    phase_t              phase;
    logic [BYTE_W-1:0]   cmd;
    logic [WORD_W-1:0]   len;
    logic [WORD_W-1:0]   cnt;
    logic [BYTE_W-1:0]   xsum;
  } state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   sync1;
    logic [BYTE_W-1:0]   sync2;
    logic [WORD_W-1:0]   max_pl;
  } cfg_t;

  typedef struct packed {
    logic                vld;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   cmd;
    logic [BYTE_W-1:0]   payload;
    logic [WORD_W-1:0]   idx;
    logic [WORD_W-1:0]   len;
  } result_t;

endpackage

// ===== hdl/xcpd_step.sv =====
module xcpd_step (
  input  xcpd_pkg::state_t  st,
  input  xcpd_pkg::cfg_t    cfg,
  input  logic [7:0]        rx_byte,
  output xcpd_pkg::state_t  st_nxt,
  output xcpd_pkg::result_t res
);
  import xcpd_pkg::*;

  logic [WORD_W-1:0] len_full;
  logic [WORD_W:0]   len_bound;
  logic              len_bad;
  logic [WORD_W-1:0] cnt_inc;

  assign len_full  = {st.len[WORD_W-1:BYTE_W], rx_byte};
  assign len_bound = {1'b0, cfg.max_pl} + (WORD_W+1)'(2);
  assign len_bad   = {1'b0, len_full} > len_bound;
  assign cnt_inc   = st.cnt + WORD_W'(1);

  // next state
  always_comb begin
    st_nxt = st;
    unique case (st.phase)
      PH_SYNC2: begin
        st_nxt.phase = (rx_byte == cfg.sync2) ? PH_CMD : PH_SYNC1;
      end
      PH_CMD: begin
        st_nxt.cmd   = rx_byte;
        st_nxt.xsum  = rx_byte;
        st_nxt.phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        st_nxt.len   = {rx_byte, {BYTE_W{1'b0}}};
        st_nxt.xsum  = st.xsum ^ rx_byte;
        st_nxt.phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        st_nxt.len  = len_full;
        st_nxt.xsum = st.xsum ^ rx_byte;
        st_nxt.cnt  = '0;
        if (len_bad) begin
          st_nxt.phase = PH_SYNC1;
        end else if (len_full == '0) begin
          st_nxt.phase = PH_CHECK;
        end else begin
          st_nxt.phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        st_nxt.xsum = st.xsum ^ rx_byte;
        st_nxt.cnt  = cnt_inc;
        if (cnt_inc == st.len) begin
          st_nxt.phase = PH_CHECK;
        end
      end
      PH_CHECK: begin
        st_nxt.phase = PH_SYNC1;
      end
      default: begin
        st_nxt.phase = (rx_byte == cfg.sync1) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  // result
  always_comb begin
    res         = '0;
    res.cmd     = st.cmd;
    res.len     = st.len;
    unique case (st.phase)
      PH_LEN_LO: begin
        res.vld  = len_bad;
        res.kind = KIND_BADLEN;
        res.len  = len_full;
      end
      PH_PAYLOAD: begin
        res.vld     = 1'b1;
        res.kind    = KIND_DATA;
        res.payload = rx_byte;
        res.idx     = st.cnt;
      end
      PH_CHECK: begin
        res.vld  = 1'b1;
        res.kind = (rx_byte == st.xsum) ? KIND_GOOD : KIND_BADSUM;
      end
      default: begin
        res.vld = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/xor_checked_packet_deframer_core.sv =====
// path: a beat accepted into the input register goes through the parse step, and its result
//   is registered on out_ (no result for sync bytes, nor for header bytes but a too-long length)
// throughput: one byte per cycle while out_ is not stalled by out_tready, set by the parse step
//   between the input register and the result register
// reset (rst_n low, synchronous): hunting for the first sync byte, both stages empty,
//   registers back to sync 0xAA / 0x55 and max payload 256
module xor_checked_packet_deframer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [47:0]                   out_tdata,  // command, payload_byte, byte_index, length
  output logic [1:0]                    out_tuser,  // kind
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [xcpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data
);
  import xcpd_pkg::*;

  cfg_t              cfg_r;
  state_t            st_r;
  state_t            st_nxt;
  result_t           res;
  logic              in_v_r;
  logic              in_v_nxt;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_v_r;
  logic              out_v_nxt;
  logic [KIND_W-1:0] out_kind_r;
  logic [47:0]       out_data_r;
  logic              adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync1  <= SYNC1_RST;
      cfg_r.sync2  <= SYNC2_RST;
      cfg_r.max_pl <= MAX_PL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC1:  cfg_r.sync1  <= cfg_data[BYTE_W-1:0];
        CFG_SYNC2:  cfg_r.sync2  <= cfg_data[BYTE_W-1:0];
        CFG_MAX_PL: cfg_r.max_pl <= cfg_data;
        default:    cfg_r        <= cfg_r;
      endcase
    end
  end

  // input stage moves on when the result slot is free or being drained
  assign adv       = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || adv;
  assign in_v_nxt  = in_tready ? in_tvalid : in_v_r;

  always_comb begin
    out_v_nxt = out_v_r && !out_tready;
    if (adv && res.vld) begin
      out_v_nxt = 1'b1;
    end
  end

  xcpd_step u_step (
    .st      (st_r),
    .cfg     (cfg_r),
    .rx_byte (in_byte_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= '{phase: PH_SYNC1, default: '0};
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (adv && res.vld) begin
      out_kind_r <= res.kind;
      out_data_r <= {res.len, res.idx, res.payload, res.cmd};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = out_data_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_DATA |-> out_tdata[31:16] < out_tdata[47:32])
    else $error("payload index not below declared length");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_DATA |-> out_tdata[31:8] == '0)
    else $error("status beat carries payload or index");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_byte_r) && $stable(st_r))
    else $error("stalled byte lost or state moved");

  a_payload_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_PAYLOAD |-> st_r.len != '0)
    else $error("payload phase with zero length");

endmodule
